// File: design/stri_pkg.sv
// Shared types and constants for the script text reindenter.
package stri_pkg;

  localparam int MAX_INDENT      = 4;   // brace nesting that still adds indentation
  localparam int MAX_RESULTS     = 64;  // bytes emitted per source byte, at most
  localparam int NSEG            = 6;   // runs of spaces + one byte, per source byte
  localparam int TOTAL_W         = 7;   // holds the uncapped byte count of one run
  localparam int SEG_IW          = $clog2(NSEG);
  localparam int SEG_CW          = $clog2(NSEG + 1);
  localparam int OUT_CW          = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH_DEF = 4;

  // Input item.
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } src_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_done;
  } res_t;

  // nsp spaces, then ch if has is set.
  typedef struct packed {
    logic [4:0] nsp;
    logic [7:0] ch;
    logic       has;
  } seg_t;

  // Work for the back end: everything one source byte expands into.
  typedef struct packed {
    seg_t [NSEG-1:0]    segs;
    logic [TOTAL_W-1:0] total;  // bytes to emit, already capped
    logic               blank;  // nothing to emit: closing result only
    logic               fin;    // last source byte of the text
  } cmd_t;

endpackage

// File: design/script_text_reindenter_unit.sv
// Top level of the script text reindenter: front end, command queue, back end.
// Usage:
//   Source bytes enter as items on the queue-style input: an item is taken
//   at a clock edge where push is high and full is low. Each item carries
//   one source byte and an end_of_text flag marking the final byte.
//   Formatted bytes leave on the result side: while empty is low the oldest
//   result sits on res, and pop at that edge takes it.
//   The front end classifies a byte in the cycle it is taken and writes a
//   command describing its whole expansion (held spaces, up to five bytes,
//   trailing spaces) into a QUEUE_DEPTH entry queue. A byte that expands to
//   nothing writes no command unless it ends the text. The back end walks one
//   command and emits one byte per cycle into the output register.
//   With an empty queue and a free output, an item's command is written into
//   the queue and its first result then into the output register.
//   Throughput: input takes one item per cycle while the queue has room;
//   output runs at one byte per cycle while the receiver keeps up, and the
//   back end finishes one item's bytes before it starts on the next item's.
//   A stalled receiver holds the output register and stops the back end; the
//   front keeps taking items until the queue fills, then raises full.
//   Reset (synchronous, rst high) clears queue, counters and formatter state.
module script_text_reindenter_unit import stri_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // power of two, 2 or more
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  src_t src,
  output logic empty,
  input  logic pop,
  output res_t res
);

  // front -> queue
  logic q_wr;
  cmd_t q_wdata;
  // queue -> back
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  stri_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .src    (src),
    .q_full (full),
    .q_wr   (q_wr),
    .cmd    (q_wdata)
  );

  stri_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // Back end drains the queue head a byte at a time.
  stri_back u_back (
    .clk     (clk),
    .rst     (rst),
    .ent     (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

endmodule

// File: design/stri_front.sv
// Front end: accepts source bytes, tracks formatter state, builds the expansion command.
module stri_front import stri_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  src_t src,
  input  logic q_full,
  output logic q_wr,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_PLUS  = 2'd1,
    HOLD_MINUS = 2'd2,
    HOLD_EQ    = 2'd3
  } hold_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_OTHER   = 2'd2
  } kind_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;

  localparam logic signed [4:0] IND_MAX = 5'(MAX_INDENT);
  localparam logic signed [4:0] IND_MIN = 5'b10000;
  localparam logic [4:0]        SP_MAX  = 5'd31;

  // Working state while one byte is expanded.
  typedef struct packed {
    logic [4:0]         pend;
    logic               als;
    kind_t              kind;
    logic [SEG_CW-1:0]  nseg;
    logic [TOTAL_W-1:0] total;
    seg_t [NSEG-1:0]    segs;
  } emu_t;

  function automatic emu_t add_sp(emu_t s, logic [4:0] n);
    emu_t       r;
    logic [5:0] sum;
    r   = s;
    sum = {1'b0, s.pend} + {1'b0, n};
    r.pend = (sum > {1'b0, SP_MAX}) ? SP_MAX : sum[4:0];
    return r;
  endfunction

  // Spaces that a flush emits: all of them at line start, else at most one.
  function automatic logic [4:0] flush_n(emu_t s);
    if (s.als) return s.pend;
    return (s.pend != '0) ? 5'd1 : 5'd0;
  endfunction

  function automatic emu_t put_c(emu_t s, logic [7:0] ch);
    emu_t       r;
    logic [4:0] n;
    r = s;
    if (ch == CH_SP) begin
      r = add_sp(r, 5'd1);
    end else begin
      n = flush_n(r);
      for (int i = 0; i < NSEG; i++) begin
        if (r.nseg == SEG_CW'(i)) begin
          r.segs[i].nsp = n;
          r.segs[i].ch  = ch;
          r.segs[i].has = 1'b1;
        end
      end
      r.nseg  = r.nseg + SEG_CW'(1);
      r.total = r.total + TOTAL_W'(n) + TOTAL_W'(1);
      r.pend  = '0;
      r.als   = (ch == CH_LF);
      r.kind  = (ch == CH_LF) ? KIND_NEWLINE : KIND_OTHER;
    end
    return r;
  endfunction

  // End-of-text flush of held spaces, no byte after them.
  function automatic emu_t flush_tail(emu_t s);
    emu_t       r;
    logic [4:0] n;
    r = s;
    n = flush_n(r);
    if (n != '0) begin
      for (int i = 0; i < NSEG; i++) begin
        if (r.nseg == SEG_CW'(i)) begin
          r.segs[i].nsp = n;
          r.segs[i].ch  = '0;
          r.segs[i].has = 1'b0;
        end
      end
      r.nseg  = r.nseg + SEG_CW'(1);
      r.total = r.total + TOTAL_W'(n);
    end
    r.pend = '0;
    return r;
  endfunction

  function automatic emu_t put_ind(emu_t s, logic signed [4:0] lvl);
    emu_t r;
    r = s;
    if (!lvl[4] && lvl != '0) r = add_sp(r, {lvl[2:0], 2'b00});
    return r;
  endfunction

  function automatic emu_t release_op(emu_t s, hold_t h);
    emu_t r;
    r = s;
    case (h)
      HOLD_PLUS:  r = put_c(r, CH_PLUS);
      HOLD_MINUS: r = put_c(r, CH_MINUS);
      HOLD_EQ: begin
        r = put_c(r, CH_SP);
        r = put_c(r, CH_EQ);
        r = put_c(r, CH_SP);
      end
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic emu_t brace_break(emu_t s);
    emu_t r;
    r = s;
    r.pend = '0;
    if (r.kind == KIND_OTHER) r = put_c(r, CH_LF);
    return r;
  endfunction

  // Formatter state
  logic signed [4:0] indent, indent_next;
  logic              inq, inq_next;
  logic              qsingle, qsingle_next;
  logic              esc, esc_next;
  hold_t             held, held_next;
  logic [4:0]        pend;
  logic              als;
  kind_t             kind;

  emu_t       e;
  logic [7:0] c;
  logic       acc;

  assign c   = src.source_byte;
  assign acc = push && !q_full;

  always_comb begin
    e            = '0;
    e.pend       = pend;
    e.als        = als;
    e.kind       = kind;
    indent_next  = indent;
    inq_next     = inq;
    qsingle_next = qsingle;
    esc_next     = esc;
    held_next    = held;

    if (held != HOLD_NONE && c == CH_EQ) begin
      if (held == HOLD_EQ) begin
        e = put_c(e, CH_EQ);
        e = put_c(e, CH_EQ);
      end else begin
        e = put_c(e, CH_SP);
        e = put_c(e, (held == HOLD_PLUS) ? CH_PLUS : CH_MINUS);
        e = put_c(e, CH_EQ);
        e = put_c(e, CH_SP);
      end
      held_next = HOLD_NONE;
    end else begin
      e = release_op(e, held);
      held_next = HOLD_NONE;
      if (inq) begin
        e = put_c(e, c);
        if (esc) begin
          esc_next = 1'b0;
        end else if (c == CH_BS) begin
          esc_next = 1'b1;
        end else if (c == (qsingle ? CH_SQ : CH_DQ)) begin
          inq_next = 1'b0;
        end
      end else begin
        case (c)
          CH_DQ, CH_SQ: begin
            inq_next     = 1'b1;
            qsingle_next = (c == CH_SQ);
            e = put_c(e, c);
          end
          CH_SP, CH_TAB: begin
            if (e.pend == '0 && e.kind == KIND_OTHER) e = put_c(e, CH_SP);
          end
          CH_PLUS:  held_next = HOLD_PLUS;
          CH_MINUS: held_next = HOLD_MINUS;
          CH_EQ:    held_next = HOLD_EQ;
          CH_LBR: begin
            e = brace_break(e);
            e = put_ind(e, indent);
            e = put_c(e, CH_LBR);
            e = put_c(e, CH_LF);
            if (indent < IND_MAX) indent_next = indent + 5'sd1;
            e = put_ind(e, indent_next);
          end
          CH_RBR: begin
            e = brace_break(e);
            if (indent > IND_MIN) indent_next = indent - 5'sd1;
            e = put_ind(e, indent_next);
            e = put_c(e, CH_RBR);
            e = put_c(e, CH_LF);
            e = put_c(e, CH_LF);
            e = put_ind(e, indent_next);
          end
          CH_SEMI: begin
            e = put_c(e, CH_SEMI);
            e = put_c(e, CH_LF);
            e = put_ind(e, indent);
          end
          CH_COMMA: begin
            e = put_c(e, CH_COMMA);
            e = put_c(e, CH_SP);
          end
          default: e = put_c(e, c);
        endcase
      end
    end

    if (src.end_of_text) begin
      e = release_op(e, held_next);
      held_next = HOLD_NONE;
      e = flush_tail(e);
    end
  end

  assign cmd.segs  = e.segs;
  assign cmd.total = (e.total > TOTAL_W'(MAX_RESULTS)) ? TOTAL_W'(MAX_RESULTS) : e.total;
  assign cmd.blank = (e.total == '0);
  assign cmd.fin   = src.end_of_text;
  assign q_wr      = acc && (e.total != '0 || src.end_of_text);

  always_ff @(posedge clk) begin
    if (rst || (acc && src.end_of_text)) begin
      indent  <= '0;
      inq     <= 1'b0;
      qsingle <= 1'b0;
      esc     <= 1'b0;
      held    <= HOLD_NONE;
      pend    <= '0;
      als     <= 1'b1;
      kind    <= KIND_NONE;
    end else if (acc) begin
      indent  <= indent_next;
      inq     <= inq_next;
      qsingle <= qsingle_next;
      esc     <= esc_next;
      held    <= held_next;
      pend    <= e.pend;
      als     <= e.als;
      kind    <= e.kind;
    end
  end

  a_blank_only_at_end: assert property (@(posedge clk) disable iff (rst)
    q_wr && cmd.blank |-> cmd.fin)
    else $error("blank command pushed before end of text");

  a_indent_range: assert property (@(posedge clk) disable iff (rst)
    acc |=> (indent <= IND_MAX) && (indent >= IND_MIN))
    else $error("indent level left its range");

endmodule

// File: design/stri_fifo.sv
// Short command queue between front and back end.
module stri_fifo import stri_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output cmd_t rdata,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full  = (count == (AW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= wp + AW'(1);
      if (do_rd) rp <= rp + AW'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(DEPTH))
    else $error("queue count beyond depth");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> !empty)
    else $error("written entry not visible");

endmodule

// File: design/stri_back.sv
// Back end: expands one command into output bytes, one per cycle while the output is free.
module stri_back import stri_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t ent,
  input  logic q_empty,
  output logic q_pop,
  input  logic pop,
  output logic empty,
  output res_t res
);

  logic              ov;
  res_t              od;
  logic [SEG_IW-1:0] seg_idx;
  logic [4:0]        sp_cnt;
  logic [OUT_CW-1:0] out_cnt;

  seg_t cur;
  logic prod, last, is_sp;
  res_t nb;

  assign cur   = ent.segs[seg_idx];
  assign prod  = !q_empty && (!ov || pop);
  assign is_sp = (sp_cnt < cur.nsp);
  assign last  = ent.blank || ((TOTAL_W'(out_cnt) + TOTAL_W'(1)) == ent.total);
  assign q_pop = prod && last;

  always_comb begin
    nb.has_byte  = !ent.blank;
    nb.run_last  = last;
    nb.text_done = last && ent.fin;
    if (ent.blank) nb.out_byte = '0;
    else if (is_sp) nb.out_byte = 8'h20;
    else nb.out_byte = cur.ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov      <= 1'b0;
      seg_idx <= '0;
      sp_cnt  <= '0;
      out_cnt <= '0;
    end else begin
      if (prod) ov <= 1'b1;
      else if (pop) ov <= 1'b0;
      if (prod) begin
        if (last) begin
          seg_idx <= '0;
          sp_cnt  <= '0;
          out_cnt <= '0;
        end else begin
          out_cnt <= out_cnt + OUT_CW'(1);
          if (is_sp) begin
            sp_cnt <= sp_cnt + 5'd1;
          end else begin
            sp_cnt  <= '0;
            seg_idx <= seg_idx + SEG_IW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod) od <= nb;
  end

  assign empty = !ov;
  assign res   = od;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_within_segs: assert property (@(posedge clk) disable iff (rst)
    prod && !ent.blank |-> is_sp || cur.has)
    else $error("expansion ran past its segments");

endmodule

// File: tb/reindent_checker.sv
// Checker for the script text reindenter: predicts formatted bytes and compares them.
`timescale 1ns / 1ps

module reindent_checker import stri_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  src_t      src,
  input  logic      empty,
  input  logic      pop,
  input  res_t      res,
  output int        mismatch_count,
  output int        backlog
);

  typedef enum logic [1:0] {HELD_NONE, HELD_PLUS, HELD_MINUS, HELD_EQ} held_op_t;
  typedef enum logic [1:0] {LAST_NOTHING, LAST_NEWLINE, LAST_OTHER} last_kind_t;

  localparam int INDENT_FLOOR = -16;
  localparam int SPACE_CAP    = 31;

  // formatter state
  int         indent;
  bit         quoted;
  bit         single_quoted;
  bit         escaped;
  held_op_t   held;
  int         spaces;
  bit         line_start;
  last_kind_t last_kind;

  byte unsigned line_buf[$];     // bytes produced by the current source byte
  res_t         formatted_q[$];  // formatted bytes still owed by the block

  function automatic void clear_state();
    indent        = 0;
    quoted        = 1'b0;
    single_quoted = 1'b0;
    escaped       = 1'b0;
    held          = HELD_NONE;
    spaces        = 0;
    line_start    = 1'b1;
    last_kind     = LAST_NOTHING;
  endfunction

  function automatic void emit_raw(byte unsigned b);
    if (line_buf.size() < MAX_RESULTS) line_buf.push_back(b);
  endfunction

  function automatic void hold_spaces(int n);
    spaces = (spaces + n > SPACE_CAP) ? SPACE_CAP : spaces + n;
  endfunction

  // whole run at line start, else a single space
  function automatic void release_spaces();
    if (line_start) begin
      for (int k = 0; k < spaces; k++) emit_raw(" ");
    end else if (spaces > 0) begin
      emit_raw(" ");
    end
    spaces = 0;
  endfunction

  function automatic void write_char(byte unsigned c);
    if (c == " ") begin
      hold_spaces(1);
      return;
    end
    release_spaces();
    emit_raw(c);
    line_start = (c == "\n");
    last_kind  = (c == "\n") ? LAST_NEWLINE : LAST_OTHER;
  endfunction

  function automatic void indent_spaces();
    if (indent > 0) hold_spaces(indent * 4);
  endfunction

  function automatic void brace_break();
    spaces = 0;
    if (last_kind == LAST_OTHER) write_char("\n");
  endfunction

  function automatic void release_operator();
    case (held)
      HELD_PLUS:  write_char("+");
      HELD_MINUS: write_char("-");
      HELD_EQ: begin
        write_char(" ");
        write_char("=");
        write_char(" ");
      end
      default: ;
    endcase
    held = HELD_NONE;
  endfunction

  function automatic void format_plain(byte unsigned c);
    if (quoted) begin
      write_char(c);
      if (escaped) escaped = 1'b0;
      else if (c == "\\") escaped = 1'b1;
      else if (c == (single_quoted ? "'" : "\"")) quoted = 1'b0;
      return;
    end
    case (c)
      "\"", "'": begin
        quoted        = 1'b1;
        single_quoted = (c == "'");
        write_char(c);
      end
      " ", "\t": if (spaces == 0 && last_kind == LAST_OTHER) write_char(" ");
      "+": held = HELD_PLUS;
      "-": held = HELD_MINUS;
      "=": held = HELD_EQ;
      "{": begin
        brace_break();
        indent_spaces();
        write_char("{");
        write_char("\n");
        if (indent < MAX_INDENT) indent++;
        indent_spaces();
      end
      "}": begin
        brace_break();
        if (indent > INDENT_FLOOR) indent--;
        indent_spaces();
        write_char("}");
        write_char("\n");
        write_char("\n");
        indent_spaces();
      end
      ";": begin
        write_char(";");
        write_char("\n");
        indent_spaces();
      end
      ",": begin
        write_char(",");
        write_char(" ");
      end
      default: write_char(c);
    endcase
  endfunction

  function automatic void format_byte(byte unsigned c);
    if (held != HELD_NONE && c == "=") begin
      if (held == HELD_EQ) begin
        write_char("=");
        write_char("=");
      end else begin
        write_char(" ");
        write_char(held == HELD_PLUS ? "+" : "-");
        write_char("=");
        write_char(" ");
      end
      held = HELD_NONE;
      return;
    end
    release_operator();
    format_plain(c);
  endfunction

  // expands one accepted source byte into the results it owes
  function automatic void reformat_item(src_t s);
    res_t r;
    int   n;
    line_buf.delete();
    format_byte(s.source_byte);
    if (s.end_of_text) begin
      release_operator();
      release_spaces();
    end
    n = line_buf.size();
    if (n == 0) begin
      if (s.end_of_text) begin
        r.out_byte  = 8'h00;
        r.has_byte  = 1'b0;
        r.run_last  = 1'b1;
        r.text_done = 1'b1;
        formatted_q.push_back(r);
        clear_state();
      end
      return;
    end
    for (int k = 0; k < n; k++) begin
      r.out_byte  = line_buf[k];
      r.has_byte  = 1'b1;
      r.run_last  = (k == n - 1);
      r.text_done = (k == n - 1) && s.end_of_text;
      formatted_q.push_back(r);
    end
    if (s.end_of_text) clear_state();
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      clear_state();
      formatted_q.delete();
    end else begin
      // results first: an item taken at this edge cannot show up yet
      if (pop && !empty) begin
        if (formatted_q.size() == 0) begin
          $error("unexpected result: out_byte %0h", res.out_byte);
          mismatch_count++;
        end else begin
          want = formatted_q.pop_front();
          check_field("out_byte", want.out_byte, res.out_byte);
          check_field("has_byte", want.has_byte, res.has_byte);
          check_field("run_last", want.run_last, res.run_last);
          check_field("text_done", want.text_done, res.text_done);
        end
      end
      if (push && !full) reformat_item(src);
    end
    backlog <= formatted_q.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the reindenter testbench: clock, reset, source text stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import stri_pkg::*;

  localparam int RANDOM_ITEMS = 350;
  localparam int STALL_LIMIT  = 1000;  // idle cycles before the run is declared hung
  localparam int DRAIN_CYCLES = 20;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic full;
  src_t src  = '0;
  logic empty;
  logic pop  = 1'b0;
  res_t res;

  int mismatch_count;
  int backlog;       // results the checker still expects
  int stall_cycles = 0;
  bit steady = 1'b0; // both sides run without gaps while set

  byte unsigned script_q[$];  // source text waiting to be sent

  script_text_reindenter_unit uut (
    .clk, .rst, .push, .full, .src, .empty, .pop, .res
  );

  reindent_checker watch (
    .clk, .rst, .push, .full, .src, .empty, .pop, .res,
    .mismatch_count, .backlog
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hang detector: nothing taken on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One item on the input side. Inputs only change right after a rising
  // edge; acceptance is judged at the falling edge, where full is stable.
  task automatic send_source(input byte unsigned b, input bit eot);
    int gap;
    bit taken;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    src  <= '{source_byte: b, end_of_text: eot};
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
  endtask

  // Hold off until every owed result has drained.
  task automatic wait_drained();
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic byte unsigned word_char();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(48, 57))
                                       : 8'($urandom_range(97, 122));
  endfunction

  // Appends one piece of script-like text: mostly well-formed tokens,
  // with some raw noise bytes and long brace runs to hit indent limits.
  function automatic void compose_fragment();
    int           pick;
    int           n;
    byte unsigned qc;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(1, 6);
      repeat (n) script_q.push_back(word_char());
    end else if (pick < 40) begin
      case ($urandom_range(0, 2))
        0: script_q.push_back("+");
        1: script_q.push_back("-");
        default: script_q.push_back("=");
      endcase
      if ($urandom_range(0, 1) == 1) script_q.push_back("=");
    end else if (pick < 50) begin
      script_q.push_back(";");
    end else if (pick < 55) begin
      script_q.push_back(",");
    end else if (pick < 63) begin
      script_q.push_back("{");
    end else if (pick < 71) begin
      script_q.push_back("}");
    end else if (pick < 81) begin
      n = $urandom_range(1, 4);
      repeat (n) script_q.push_back($urandom_range(0, 1) ? " " : "\t");
    end else if (pick < 89) begin
      // quoted string with escapes; now and then a space run near or past the cap
      qc = $urandom_range(0, 1) ? "\"" : "'";
      script_q.push_back(qc);
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 9))
          6, 7: script_q.push_back(" ");
          8: begin
            script_q.push_back("\\");
            script_q.push_back($urandom_range(0, 1) ? qc : 8'($urandom_range(0, 255)));
          end
          9: script_q.push_back(qc == "'" ? "\"" : "'");
          default: script_q.push_back(word_char());
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(30, 40);
        repeat (n) script_q.push_back(" ");
      end
      if ($urandom_range(0, 9) != 0) script_q.push_back(qc);
    end else if (pick < 95) begin
      script_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      repeat (22) script_q.push_back("}");  // walks indent down to its floor
    end else begin
      repeat (6) script_q.push_back("{");   // past the top indent level
    end
  endfunction

  // Result side: random stall per result, none while steady.
  initial begin
    int gap;
    bit taken;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        taken = !empty;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin
    byte unsigned opening[$];
    int           sent;
    int           text_left;

    // Directed text: held operators, both joined with = and released, quotes
    // with an escaped quote, comma, tab, braces, semicolon, both extreme bytes,
    // then an end of text that closes with nothing to flush.
    opening = '{"x", "+", "=", "-", "y", "=", "=", "=", "z",
                "\"", "\\", "\"", " ", "\"", "'", "q", "'",
                ",", "\t", "{", ";", "}", 8'hFF, 8'h00, " "};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_source(opening[i], i >= 23);

    sent      = 0;
    text_left = $urandom_range(20, 80);
    while (sent < RANDOM_ITEMS) begin
      if (sent == 100) steady = 1'b1;
      if (sent == 160) steady = 1'b0;
      if (sent == 220) begin
        // sender holds off until the block has caught up completely
        push <= 1'b0;
        wait_drained();
      end
      if (script_q.size() == 0) compose_fragment();
      text_left--;
      send_source(script_q.pop_front(), text_left == 0 || sent == RANDOM_ITEMS - 1);
      if (text_left == 0) text_left = $urandom_range(20, 80);
      sent++;
    end
    push <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
